@@ src/swt_pkg.sv @@
package swt_pkg;

    localparam int CHUNK_W     = 64;
    localparam int COUNT_W     = 31;
    localparam int POS_W       = 14;
    localparam int STATUS_W    = 2;
    localparam int KEY_LEN_W   = 7;
    localparam int MAX_KEY_LEN = 50;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [CHUNK_W-1:0] key_chunk;
        logic               chunk_last;
        logic [COUNT_W-1:0] entry_count;
    } in_req_t;

    typedef struct packed {
        logic                found;
        logic [COUNT_W-1:0]  match_count;
        logic [POS_W-1:0]    match_position;
        logic [STATUS_W-1:0] status;
    } out_rsp_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_APPEND_BAD,
        OP_QUERY,
        OP_QUERY_BAD
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [COUNT_W-1:0] count;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WRITE,
        BK_MID,
        BK_READ,
        BK_CMP
    } back_state_t;

endpackage

@@ src/swt_front.sv @@
module swt_front #(
    parameter int KEY_BYTES = 56,
    parameter int KC        = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  swt_pkg::in_req_t         req,
    input  logic                     q_full,
    output logic                     push,
    output swt_pkg::cmd_t            push_cmd,
    output logic [KC-1:0][63:0]      push_key
);
    import swt_pkg::*;

    localparam int CW  = $clog2(KC + 1);
    localparam int CIW = (KC > 1) ? $clog2(KC) : 1;

    logic [KC-1:0][CHUNK_W-1:0] buf_reg, buf_upd;
    logic [CW-1:0]              ci_reg, ci_next;
    logic                       term_reg, term_next;
    logic [KEY_LEN_W-1:0]       len_reg, len_next;

    logic                       accept;
    logic                       chunk_fresh;
    logic [CHUNK_W-1:0]         masked;
    logic [9:0]                 bpos;
    logic                       key_ok;
    logic [KEY_LEN_W-1:0]       key_len;
    logic                       key_op;

    assign req_ready   = !q_full;
    assign accept      = req_valid && req_ready;
    assign chunk_fresh = ci_reg < CW'(KC);
    assign key_op      = (req.action == ACT_APPEND) || (req.action == ACT_QUERY);

    // mask bytes past the terminator or past the key width, track first zero
    always_comb
    begin
        masked    = req.key_chunk;
        term_next = term_reg;
        len_next  = len_reg;
        bpos      = '0;
        if (chunk_fresh)
        begin
            for (int j = 0; j < 8; j++)
            begin
                bpos = (10'(ci_reg) << 3) + 10'(j);
                if (term_next || bpos >= 10'(KEY_BYTES))
                begin
                    masked[j*8 +: 8] = 8'd0;
                end
                else if (req.key_chunk[j*8 +: 8] == 8'd0)
                begin
                    term_next = 1'b1;
                    len_next  = KEY_LEN_W'(bpos);
                end
            end
        end
    end

    always_comb
    begin
        buf_upd = buf_reg;
        ci_next = ci_reg;
        if (chunk_fresh)
        begin
            buf_upd[ci_reg[CIW-1:0]] = masked;
            ci_next = ci_reg + CW'(1);
        end
    end

    // unwritten chunks are zero, so their first byte terminates the key
    always_comb
    begin
        key_ok  = 1'b1;
        key_len = len_next;
        if (!term_next)
        begin
            if (ci_next < CW'(KC))
            begin
                key_len = KEY_LEN_W'(ci_next) << 3;
            end
            else
            begin
                key_ok  = 1'b0;
                key_len = '0;
            end
        end
    end

    always_comb
    begin
        push           = 1'b0;
        push_cmd.op    = OP_CLEAR;
        push_cmd.count = req.entry_count;
        push_key       = buf_upd;
        if (accept)
        begin
            if (req.action == ACT_CLEAR)
            begin
                push        = 1'b1;
                push_cmd.op = OP_CLEAR;
            end
            else if (key_op && req.chunk_last)
            begin
                push = 1'b1;
                if (req.action == ACT_APPEND)
                begin
                    if (key_ok && key_len != '0 && key_len <= KEY_LEN_W'(MAX_KEY_LEN))
                        push_cmd.op = OP_APPEND;
                    else
                        push_cmd.op = OP_APPEND_BAD;
                end
                else
                begin
                    push_cmd.op = key_ok ? OP_QUERY : OP_QUERY_BAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            ci_reg   <= '0;
            term_reg <= 1'b0;
            len_reg  <= '0;
        end
        else if (accept)
        begin
            if (req.action == ACT_CLEAR || (key_op && req.chunk_last))
            begin
                buf_reg  <= '0;
                ci_reg   <= '0;
                term_reg <= 1'b0;
                len_reg  <= '0;
            end
            else if (key_op)
            begin
                buf_reg  <= buf_upd;
                ci_reg   <= ci_next;
                term_reg <= term_next;
                len_reg  <= len_next;
            end
        end
    end

endmodule

@@ src/swt_queue.sv @@
module swt_queue #(
    parameter int KC = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  swt_pkg::cmd_t       push_cmd,
    input  logic [KC-1:0][63:0] push_key,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output swt_pkg::cmd_t       head_cmd,
    output logic [KC-1:0][63:0] head_key
);
    import swt_pkg::*;

    cmd_t                       cmd_q [2];
    logic [KC-1:0][CHUNK_W-1:0] key_q [2];
    logic                       wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                 fill_reg;

    assign full     = fill_reg == 2'd2;
    assign empty    = fill_reg == 2'd0;
    assign head_cmd = cmd_q[rd_ptr_reg];
    assign head_key = key_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            cmd_q[wr_ptr_reg] <= push_cmd;
            key_q[wr_ptr_reg] <= push_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop && !empty)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'((push && !full) ? 1 : 0)
                                 - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

@@ src/swt_back.sv @@
module swt_back #(
    parameter int TABLE_DEPTH = 16384,
    parameter int KC          = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  swt_pkg::cmd_t       head_cmd,
    input  logic [KC-1:0][63:0] head_key,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output swt_pkg::out_rsp_t   result
);
    import swt_pkg::*;

    localparam int EW  = $clog2(TABLE_DEPTH + 1);
    localparam int TW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int AW  = $clog2(TABLE_DEPTH * KC);
    localparam int CIW = (KC > 1) ? $clog2(KC) : 1;

    logic [CHUNK_W-1:0] key_mem   [TABLE_DEPTH * KC];
    logic [COUNT_W-1:0] count_mem [TABLE_DEPTH];

    back_state_t        state_reg, state_next;
    logic [EW-1:0]      entries_reg, entries_next;
    logic [EW-1:0]      lower_reg, lower_next;
    logic [EW-1:0]      upper_reg, upper_next;
    logic [TW-1:0]      mid_reg, mid_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [CIW-1:0]     idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    out_rsp_t           out_reg, out_next;

    logic [CHUNK_W-1:0] key_rd_reg;
    logic [COUNT_W-1:0] count_rd_reg;
    logic               key_we, count_we;
    logic [AW-1:0]      key_addr;
    logic [CHUNK_W-1:0] key_chunk;
    logic [CHUNK_W-1:0] ent_rev, key_rev;
    logic [EW:0]        bound_sum;
    logic               slot_free;
    logic               last_idx;

    function automatic logic [63:0] byte_rev(input logic [63:0] w);
        logic [63:0] r;
        for (int j = 0; j < 8; j++)
            r[j*8 +: 8] = w[(7-j)*8 +: 8];
        return r;
    endfunction

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign slot_free    = !out_valid_reg || result_ready;
    assign key_addr     = base_reg + AW'(idx_reg);
    assign key_chunk    = head_key[idx_reg];
    assign ent_rev      = byte_rev(key_rd_reg);
    assign key_rev      = byte_rev(key_chunk);
    assign bound_sum    = (EW+1)'(lower_reg) + (EW+1)'(upper_reg);
    assign last_idx     = idx_reg == CIW'(KC - 1);

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_addr] <= key_chunk;
        if (count_we)
            count_mem[entries_reg[TW-1:0]] <= head_cmd.count;
        key_rd_reg   <= key_mem[key_addr];
        count_rd_reg <= count_mem[mid_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        entries_next   = entries_reg;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        mid_next       = mid_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        key_we         = 1'b0;
        count_we       = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty && slot_free)
                begin
                    out_next = '0;
                    case (head_cmd.op)
                        OP_CLEAR:
                        begin
                            entries_next = '0;
                            pop          = 1'b1;
                        end
                        OP_APPEND_BAD, OP_QUERY_BAD:
                        begin
                            out_next.status = ST_BAD_KEY;
                            out_valid_next  = 1'b1;
                            pop             = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            if (entries_reg >= EW'(TABLE_DEPTH))
                            begin
                                out_next.status = ST_FULL;
                                out_valid_next  = 1'b1;
                                pop             = 1'b1;
                            end
                            else
                            begin
                                base_next  = AW'(entries_reg) * AW'(KC);
                                idx_next   = '0;
                                state_next = BK_WRITE;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (entries_reg == '0)
                            begin
                                out_next.status = ST_DONE;
                                out_valid_next  = 1'b1;
                                pop             = 1'b1;
                            end
                            else
                            begin
                                lower_next = '0;
                                upper_next = entries_reg;
                                state_next = BK_MID;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_WRITE:
            begin
                key_we = 1'b1;
                if (last_idx)
                begin
                    count_we        = 1'b1;
                    entries_next    = entries_reg + EW'(1);
                    out_next        = '0;
                    out_next.status = ST_DONE;
                    out_valid_next  = 1'b1;
                    pop             = 1'b1;
                    state_next      = BK_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CIW'(1);
                end
            end
            BK_MID:
            begin
                mid_next   = TW'(bound_sum >> 1);
                base_next  = AW'(mid_next) * AW'(KC);
                idx_next   = '0;
                state_next = BK_READ;
            end
            BK_READ:
            begin
                state_next = BK_CMP;
            end
            BK_CMP:
            begin
                if (ent_rev == key_rev)
                begin
                    if (last_idx)
                    begin
                        out_next.found          = 1'b1;
                        out_next.match_count    = count_rd_reg;
                        out_next.match_position = POS_W'(mid_reg);
                        out_next.status         = ST_DONE;
                        out_valid_next          = 1'b1;
                        pop                     = 1'b1;
                        state_next              = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CIW'(1);
                        state_next = BK_READ;
                    end
                end
                else if (EW'(mid_reg) == lower_reg)
                begin
                    out_next        = '0;
                    out_next.status = ST_DONE;
                    out_valid_next  = 1'b1;
                    pop             = 1'b1;
                    state_next      = BK_IDLE;
                end
                else
                begin
                    // table is taken as descending
                    if (ent_rev > key_rev)
                        lower_next = EW'(mid_reg);
                    else
                        upper_next = EW'(mid_reg);
                    state_next = BK_MID;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            entries_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            entries_reg   <= entries_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lower_reg <= lower_next;
        upper_reg <= upper_next;
        mid_reg   <= mid_next;
        base_reg  <= base_next;
        idx_reg   <= idx_next;
        out_reg   <= out_next;
    end

endmodule

@@ src/sorted_word_table_lookup.sv @@
// Chunks are taken one per cycle unless the request queue is full; a key is assembled chunk by chunk.
// Append: if the table is not full, the back end writes one key memory word per chunk, result registered.
// Query: up to log2(n)+1 probes, each comparing up to m chunks one at a time through the
// registered key memory read port; a mismatching chunk ends the probe.
// A two-deep request queue parts assembly from the search engine.
// Reset clears entry count, key buffer and queue; table memories are not cleared.
module sorted_word_table_lookup #(
    parameter int TABLE_DEPTH = 16384,
    parameter int KEY_BYTES   = 56
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  swt_pkg::in_req_t  req,
    output logic              result_valid,
    input  logic              result_ready,
    output swt_pkg::out_rsp_t result
);
    import swt_pkg::*;

    localparam int KC = (KEY_BYTES + 7) / 8;

    logic                       q_full, q_empty, push, pop;
    cmd_t                       push_cmd, head_cmd;
    logic [KC-1:0][CHUNK_W-1:0] push_key, head_key;

    swt_front #(
        .KEY_BYTES (KEY_BYTES),
        .KC        (KC)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd),
        .push_key  (push_key)
    );

    swt_queue #(
        .KC (KC)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .push_key (push_key),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_cmd (head_cmd),
        .head_key (head_key)
    );

    swt_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KC          (KC)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_cmd     (head_cmd),
        .head_key     (head_key),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
